>>> hdl/deq_pkg.sv
// Shared types, constants and slot arithmetic for the double-ended queue.
// No dependencies; used by deq_ctrl and double_ended_queue_top.
package deq_pkg;

    // ring size and derived widths
    localparam int DEPTH  = 32;
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 64;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [WORD_W-1:0] word_t;

    // command codes
    localparam logic [2:0] MODE_PUSH_HEAD = 3'd0;
    localparam logic [2:0] MODE_PUSH_TAIL = 3'd1;
    localparam logic [2:0] MODE_POP_HEAD  = 3'd2;
    localparam logic [2:0] MODE_POP_TAIL  = 3'd3;
    localparam logic [2:0] MODE_PEEK_HEAD = 3'd4;
    localparam logic [2:0] MODE_PEEK_TAIL = 3'd5;
    localparam logic [2:0] MODE_DUMP_FWD  = 3'd6;
    localparam logic [2:0] MODE_DUMP_BWD  = 3'd7;

    // status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // one result issued by the controller; read data joins it in the next cycle
    typedef struct packed {
        logic       vld;
        logic       use_ram;
        logic [1:0] status;
        logic       last;
    } issue_t;

    // next slot around the ring
    function automatic slot_t slot_inc(input slot_t s);
        slot_t r;
        if (s == slot_t'(DEPTH - 1))
            r = '0;
        else
            r = slot_t'(s + 1'b1);
        return r;
    endfunction

    // previous slot around the ring
    function automatic slot_t slot_dec(input slot_t s);
        slot_t r;
        if (s == '0)
            r = slot_t'(DEPTH - 1);
        else
            r = slot_t'(s - 1'b1);
        return r;
    endfunction

    // (s + n) mod DEPTH for n up to DEPTH
    function automatic slot_t slot_add(input slot_t s, input cnt_t n);
        logic [CNT_W:0] sum;
        slot_t          r;
        sum = {{(CNT_W + 1 - SLOT_W){1'b0}}, s} + {1'b0, n};
        if (sum >= (CNT_W + 1)'(DEPTH))
            r = SLOT_W'(sum - (CNT_W + 1)'(DEPTH));
        else
            r = SLOT_W'(sum);
        return r;
    endfunction

endpackage

>>> hdl/deq_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module deq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/deq_ctrl.sv
// Queue controller: head and count registers, dump sequencer, RAM port control.
// Depends on deq_pkg.
module deq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          mode,
    input  deq_pkg::word_t      entry_value,
    input  logic                credit_ok,
    output deq_pkg::issue_t     issue,
    output logic                ram_we,
    output deq_pkg::slot_t      ram_waddr,
    output deq_pkg::word_t      ram_wdata,
    output logic                ram_re,
    output deq_pkg::slot_t      ram_raddr
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic            state_reg,     state_next;
    deq_pkg::slot_t  head_reg,      head_next;
    deq_pkg::cnt_t   count_reg,     count_next;
    deq_pkg::cnt_t   walk_rem_reg,  walk_rem_next;
    deq_pkg::slot_t  walk_slot_reg, walk_slot_next;
    logic            walk_fwd_reg,  walk_fwd_next;

    logic            accept;
    logic            is_empty;
    logic            is_full;
    deq_pkg::slot_t  tail_slot;
    deq_pkg::slot_t  dump_start;

    assign in_ready   = (state_reg == ST_IDLE) && credit_ok;
    assign accept     = in_valid && in_ready;
    assign is_empty   = (count_reg == '0);
    assign is_full    = (count_reg == deq_pkg::cnt_t'(deq_pkg::DEPTH));
    assign tail_slot  = deq_pkg::slot_add(head_reg, deq_pkg::cnt_t'(count_reg - 1'b1));
    assign dump_start = (mode == deq_pkg::MODE_DUMP_FWD) ? head_reg : tail_slot;

    // command decode and dump walk
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        walk_rem_next  = walk_rem_reg;
        walk_slot_next = walk_slot_reg;
        walk_fwd_next  = walk_fwd_reg;
        issue          = '0;
        ram_we         = 1'b0;
        ram_waddr      = head_reg;
        ram_wdata      = entry_value;
        ram_re         = 1'b0;
        ram_raddr      = walk_slot_reg;

        if (state_reg == ST_WALK)
        begin
            if (credit_ok)
            begin
                ram_re        = 1'b1;
                ram_raddr     = walk_slot_reg;
                issue.vld     = 1'b1;
                issue.use_ram = 1'b1;
                issue.status  = deq_pkg::STATUS_OK;
                issue.last    = (walk_rem_reg == deq_pkg::cnt_t'(1));
                walk_rem_next = deq_pkg::cnt_t'(walk_rem_reg - 1'b1);
                walk_slot_next = walk_fwd_reg ? deq_pkg::slot_inc(walk_slot_reg)
                                              : deq_pkg::slot_dec(walk_slot_reg);
                if (walk_rem_reg == deq_pkg::cnt_t'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
        end
        else if (accept)
        begin
            issue.vld    = 1'b1;
            issue.last   = 1'b1;
            issue.status = deq_pkg::STATUS_OK;
            if ((mode == deq_pkg::MODE_PUSH_HEAD) || (mode == deq_pkg::MODE_PUSH_TAIL))
            begin
                // push, dropped when full
                if (is_full)
                begin
                    issue.status = deq_pkg::STATUS_FULL;
                end
                else
                begin
                    ram_we     = 1'b1;
                    count_next = deq_pkg::cnt_t'(count_reg + 1'b1);
                    if (mode == deq_pkg::MODE_PUSH_HEAD)
                    begin
                        head_next = deq_pkg::slot_dec(head_reg);
                        ram_waddr = deq_pkg::slot_dec(head_reg);
                    end
                    else
                    begin
                        ram_waddr = deq_pkg::slot_add(head_reg, count_reg);
                    end
                end
            end
            else if (is_empty)
            begin
                issue.status = deq_pkg::STATUS_EMPTY;
            end
            else
            begin
                unique case (mode)
                    deq_pkg::MODE_POP_HEAD:
                    begin
                        head_next  = deq_pkg::slot_inc(head_reg);
                        count_next = deq_pkg::cnt_t'(count_reg - 1'b1);
                    end
                    deq_pkg::MODE_POP_TAIL:
                    begin
                        count_next = deq_pkg::cnt_t'(count_reg - 1'b1);
                    end
                    deq_pkg::MODE_PEEK_HEAD:
                    begin
                        ram_re        = 1'b1;
                        ram_raddr     = head_reg;
                        issue.use_ram = 1'b1;
                    end
                    deq_pkg::MODE_PEEK_TAIL:
                    begin
                        ram_re        = 1'b1;
                        ram_raddr     = tail_slot;
                        issue.use_ram = 1'b1;
                    end
                    default:
                    begin
                        // dump: first entry now, the rest from the walk state
                        ram_re         = 1'b1;
                        ram_raddr      = dump_start;
                        issue.use_ram  = 1'b1;
                        issue.last     = (count_reg == deq_pkg::cnt_t'(1));
                        walk_fwd_next  = (mode == deq_pkg::MODE_DUMP_FWD);
                        walk_rem_next  = deq_pkg::cnt_t'(count_reg - 1'b1);
                        walk_slot_next = (mode == deq_pkg::MODE_DUMP_FWD)
                                         ? deq_pkg::slot_inc(dump_start)
                                         : deq_pkg::slot_dec(dump_start);
                        if (count_reg != deq_pkg::cnt_t'(1))
                        begin
                            state_next = ST_WALK;
                        end
                    end
                endcase
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            walk_rem_reg  <= '0;
            walk_slot_reg <= '0;
            walk_fwd_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            walk_rem_reg  <= walk_rem_next;
            walk_slot_reg <= walk_slot_next;
            walk_fwd_reg  <= walk_fwd_next;
        end
    end

endmodule

>>> hdl/double_ended_queue_top.sv
// Bounded double-ended queue of 64-bit words in a ring buffer of
// deq_pkg::DEPTH slots held in one RAM with a registered read.
// Push, pop and peek complete on acceptance, and a new command can follow in
// the next cycle. A dump of N entries streams one word per cycle, set by the
// single RAM read port; the next command is taken after the last read.
// Results pass through a three-word output queue, so a stalled consumer does
// not lose words; the controller only issues while that queue has room.
// Storage is not cleared at reset; only written entries are ever read.
// Depends on deq_pkg, deq_ram and deq_ctrl.
module double_ended_queue_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [63:0] entry_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] read_value,
    output logic [1:0]  status,
    output logic        last_of_run
);

    localparam int OQ_DEPTH = 3;

    deq_pkg::issue_t issue;
    logic            credit_ok;
    logic            ram_we;
    deq_pkg::slot_t  ram_waddr;
    deq_pkg::word_t  ram_wdata;
    logic            ram_re;
    deq_pkg::slot_t  ram_raddr;
    deq_pkg::word_t  ram_rdata;

    deq_pkg::issue_t pend_reg;
    deq_pkg::word_t  oq_data_reg   [OQ_DEPTH];
    logic [1:0]      oq_status_reg [OQ_DEPTH];
    logic            oq_last_reg   [OQ_DEPTH];
    logic [1:0]      oq_wr_reg,  oq_wr_next;
    logic [1:0]      oq_rd_reg,  oq_rd_next;
    logic [1:0]      oq_cnt_reg, oq_cnt_next;
    logic            oq_push;
    logic            oq_pop;
    logic [2:0]      in_flight;

    deq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .entry_value (entry_value),
        .credit_ok   (credit_ok),
        .issue       (issue),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr)
    );

    deq_ram #(
        .WIDTH (deq_pkg::WORD_W),
        .DEPTH (deq_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // room for one more word counting the one waiting on RAM data
    assign in_flight = {1'b0, oq_cnt_reg} + {2'b00, pend_reg.vld};
    assign credit_ok = (in_flight < 3'(OQ_DEPTH));

    // result is registered here while the RAM read completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= issue;
        end
    end

    assign oq_push = pend_reg.vld;
    assign oq_pop  = out_valid && out_ready;

    // output queue pointers
    always_comb
    begin
        oq_wr_next  = oq_wr_reg;
        oq_rd_next  = oq_rd_reg;
        oq_cnt_next = oq_cnt_reg;
        if (oq_push)
        begin
            oq_wr_next = (oq_wr_reg == 2'(OQ_DEPTH - 1)) ? 2'd0 : 2'(oq_wr_reg + 1'b1);
        end
        if (oq_pop)
        begin
            oq_rd_next = (oq_rd_reg == 2'(OQ_DEPTH - 1)) ? 2'd0 : 2'(oq_rd_reg + 1'b1);
        end
        if (oq_push && !oq_pop)
        begin
            oq_cnt_next = 2'(oq_cnt_reg + 1'b1);
        end
        else if (oq_pop && !oq_push)
        begin
            oq_cnt_next = 2'(oq_cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            oq_wr_reg  <= oq_wr_next;
            oq_rd_reg  <= oq_rd_next;
            oq_cnt_reg <= oq_cnt_next;
        end
    end

    // output queue storage, zero word when no read was made
    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_data_reg[oq_wr_reg]   <= pend_reg.use_ram ? ram_rdata : '0;
            oq_status_reg[oq_wr_reg] <= pend_reg.status;
            oq_last_reg[oq_wr_reg]   <= pend_reg.last;
        end
    end

    assign out_valid   = (oq_cnt_reg != '0);
    assign read_value  = oq_data_reg[oq_rd_reg];
    assign status      = oq_status_reg[oq_rd_reg];
    assign last_of_run = oq_last_reg[oq_rd_reg];

endmodule
